@@ hdl/cepq_pkg.sv @@
// cepq_pkg: shared constants, codes and control types for the push-out packet queue
// no dependencies; every other file uses it
package cepq_pkg;

  // default geometry
  localparam int DEPTH_DEF    = 1024;
  localparam int ID_WIDTH_DEF = 16;

  // fixed field widths
  localparam int LIMIT_W   = 11;
  localparam int LEN_W     = 16;
  localparam int CNT_OUT_W = 11;
  localparam int BL_W      = 26;
  localparam int STATUS_W  = 3;
  localparam int ECN_W     = 2;

  // configuration port
  localparam int PADDR_W = 2;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-1:0] REG_QUEUE_LIMIT = PADDR_W'(0);
  localparam logic [LIMIT_W-1:0] LIMIT_RESET     = LIMIT_W'(1000);

  // ecn marking
  localparam logic [ECN_W-1:0] ECN_FIELD_MASK = 2'b11;
  localparam logic [ECN_W-1:0] ECN_CE_CODE    = 2'b11;

  // input command codes
  localparam logic CMD_ENQUEUE = 1'b0;
  localparam logic CMD_DEQUEUE = 1'b1;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_ENQUEUED   = 3'd0,
    ST_EVICTED    = 3'd1,
    ST_DROP_CE    = 3'd2,
    ST_DROP_FULL  = 3'd3,
    ST_DROP_ZERO  = 3'd4,
    ST_DEQUEUED   = 3'd5,
    ST_EMPTY      = 3'd6
  } status_e;

  // controller to datapath commands
  typedef struct packed {
    logic    latch_in;
    logic    rd_head;
    logic    rd_free;
    logic    rd_ring;
    logic    rd_victim;
    logic    deq_commit;
    logic    evict_commit;
    logic    alloc_commit;
    logic    res_load;
    status_e status;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic is_dequeue;
    logic is_empty;
    logic limit_zero;
    logic below_limit;
    logic arrive_ce;
    logic ce_held;
  } dp_flags_t;

endpackage

@@ hdl/cepq_if.sv @@
// cepq_in_if / cepq_out_if: valid-ready channels for packet commands and results
// depends on cepq_pkg for field widths
interface cepq_in_if #(
  parameter int ID_WIDTH = cepq_pkg::ID_WIDTH_DEF
);
  logic                                 valid;
  logic                                 ready;
  logic                                 command;
  logic [ID_WIDTH-1:0]                  packet_id;
  logic [cepq_pkg::LEN_W-1:0]           packet_length;
  logic                                 is_ip;
  logic [cepq_pkg::ECN_W-1:0]           ecn_bits;

  modport source (output valid, command, packet_id, packet_length, is_ip, ecn_bits,
                  input ready);
  modport sink   (input valid, command, packet_id, packet_length, is_ip, ecn_bits,
                  output ready);
endinterface

interface cepq_out_if #(
  parameter int ID_WIDTH = cepq_pkg::ID_WIDTH_DEF
);
  logic                                 valid;
  logic                                 ready;
  logic [cepq_pkg::STATUS_W-1:0]        status;
  logic [ID_WIDTH-1:0]                  released_id;
  logic [cepq_pkg::LEN_W-1:0]           released_length;
  logic                                 released_ce;
  logic [cepq_pkg::CNT_OUT_W-1:0]       queue_count;
  logic [cepq_pkg::CNT_OUT_W-1:0]       ce_count;
  logic [cepq_pkg::BL_W-1:0]            backlog_bytes;

  modport source (output valid, status, released_id, released_length, released_ce,
                  queue_count, ce_count, backlog_bytes, input ready);
  modport sink   (input valid, status, released_id, released_length, released_ce,
                  queue_count, ce_count, backlog_bytes, output ready);
endinterface

@@ hdl/ce_pushout_packet_queue_core.sv @@
// ce_pushout_packet_queue_core: packet descriptor queue with ce push-out
// flow: input latched, decided; dequeue reads the head slot, commits; enqueue allocates a slot;
// push-out reads ce ring, victim slot, evicts, allocates; drops and empty dequeue skip all of it;
// the result loads once the output is free; one command at a time, paced by the
// dependent slot memory reads and link writes; a waiting result does not block the next transfer
// reset: asynchronous active low; empty queue, limit 1000, slot memories need no clearing
module ce_pushout_packet_queue_core #(
  parameter int DEPTH    = cepq_pkg::DEPTH_DEF,
  parameter int ID_WIDTH = cepq_pkg::ID_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  cepq_in_if.sink                        in_i,
  cepq_out_if.source                     out_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cepq_pkg::PADDR_W-1:0]   paddr,
  input  logic [cepq_pkg::PDATA_W-1:0]   pwdata,
  output logic [cepq_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);
  import cepq_pkg::*;

  logic [LIMIT_W-1:0] queue_limit_q;
  dp_cmd_t            cmd;
  dp_flags_t          flags;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr == REG_QUEUE_LIMIT) ? PDATA_W'(queue_limit_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      queue_limit_q <= LIMIT_RESET;
    end else if (psel && penable && pwrite && (paddr == REG_QUEUE_LIMIT)) begin
      queue_limit_q <= pwdata[LIMIT_W-1:0];
    end
  end

  // sequencer
  cepq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .flags_i     (flags),
    .cmd_o       (cmd)
  );

  // storage and accounting
  cepq_dp #(
    .DEPTH    (DEPTH),
    .ID_WIDTH (ID_WIDTH)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .queue_limit_i     (queue_limit_q),
    .command_i         (in_i.command),
    .packet_id_i       (in_i.packet_id),
    .packet_length_i   (in_i.packet_length),
    .is_ip_i           (in_i.is_ip),
    .ecn_bits_i        (in_i.ecn_bits),
    .cmd_i             (cmd),
    .flags_o           (flags),
    .status_o          (out_o.status),
    .released_id_o     (out_o.released_id),
    .released_length_o (out_o.released_length),
    .released_ce_o     (out_o.released_ce),
    .queue_count_o     (out_o.queue_count),
    .ce_count_o        (out_o.ce_count),
    .backlog_bytes_o   (out_o.backlog_bytes)
  );

  // ce packets are a subset of held packets
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.ce_count <= out_o.queue_count))
    else $error("ce count exceeds queue count");

  // a pushed-out victim is always ce
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.status == ST_EVICTED)) |-> out_o.released_ce)
    else $error("evicted packet not ce");

  // an empty dequeue reports an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.status == ST_EMPTY)) |->
      ((out_o.queue_count == '0) && (out_o.backlog_bytes == '0)))
    else $error("empty status with packets held");

endmodule

@@ hdl/cepq_ctrl.sv @@
// cepq_ctrl: sequencer for one packet command at a time
// depends on cepq_pkg (command and status types)
module cepq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  cepq_pkg::dp_flags_t flags_i,
  output cepq_pkg::dp_cmd_t   cmd_o
);
  import cepq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DECIDE, S_DQ_COMMIT, S_EV_SLOT, S_EV_COMMIT, S_ALLOC, S_FINISH
  } state_e;

  state_e  state_q, state_d;
  status_e status_q, status_d;
  logic    out_valid_q, out_valid_d;
  logic    out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // next state and command decode
  always_comb begin
    cmd_o       = '0;
    cmd_o.status = status_q;
    state_d     = state_q;
    status_d    = status_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (flags_i.is_dequeue) begin
          if (flags_i.is_empty) begin
            status_d = ST_EMPTY;
            state_d  = S_FINISH;
          end else begin
            cmd_o.rd_head = 1'b1;
            status_d      = ST_DEQUEUED;
            state_d       = S_DQ_COMMIT;
          end
        end else if (flags_i.limit_zero) begin
          status_d = ST_DROP_ZERO;
          state_d  = S_FINISH;
        end else if (flags_i.below_limit) begin
          cmd_o.rd_free = 1'b1;
          status_d      = ST_ENQUEUED;
          state_d       = S_ALLOC;
        end else if (flags_i.arrive_ce) begin
          status_d = ST_DROP_CE;
          state_d  = S_FINISH;
        end else if (flags_i.ce_held) begin
          cmd_o.rd_ring = 1'b1;
          status_d      = ST_EVICTED;
          state_d       = S_EV_SLOT;
        end else begin
          status_d = ST_DROP_FULL;
          state_d  = S_FINISH;
        end
      end
      S_DQ_COMMIT: begin
        cmd_o.deq_commit = 1'b1;
        state_d          = S_FINISH;
      end
      S_EV_SLOT: begin
        cmd_o.rd_victim = 1'b1;
        state_d         = S_EV_COMMIT;
      end
      S_EV_COMMIT: begin
        cmd_o.evict_commit = 1'b1;
        state_d            = S_ALLOC;
      end
      S_ALLOC: begin
        cmd_o.alloc_commit = 1'b1;
        state_d            = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          cmd_o.res_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      status_q    <= ST_ENQUEUED;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ hdl/cepq_dp.sv @@
// cepq_dp: slot memories, linked list, free stack, ce ring, totals and result register
// depends on cepq_pkg (widths, command and status types)
module cepq_dp #(
  parameter int DEPTH    = cepq_pkg::DEPTH_DEF,
  parameter int ID_WIDTH = cepq_pkg::ID_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [cepq_pkg::LIMIT_W-1:0]      queue_limit_i,
  input  logic                              command_i,
  input  logic [ID_WIDTH-1:0]               packet_id_i,
  input  logic [cepq_pkg::LEN_W-1:0]        packet_length_i,
  input  logic                              is_ip_i,
  input  logic [cepq_pkg::ECN_W-1:0]        ecn_bits_i,
  input  cepq_pkg::dp_cmd_t                 cmd_i,
  output cepq_pkg::dp_flags_t               flags_o,
  output logic [cepq_pkg::STATUS_W-1:0]     status_o,
  output logic [ID_WIDTH-1:0]               released_id_o,
  output logic [cepq_pkg::LEN_W-1:0]        released_length_o,
  output logic                              released_ce_o,
  output logic [cepq_pkg::CNT_OUT_W-1:0]    queue_count_o,
  output logic [cepq_pkg::CNT_OUT_W-1:0]    ce_count_o,
  output logic [cepq_pkg::BL_W-1:0]         backlog_bytes_o
);
  import cepq_pkg::*;

  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int LW    = (LIMIT_W > CNT_W) ? LIMIT_W : CNT_W;
  localparam int PL_W  = ID_WIDTH + LEN_W + 1;

  // slot storage
  logic [PL_W-1:0] pl_mem   [DEPTH];
  logic [AW-1:0]   next_mem [DEPTH];
  logic [AW-1:0]   prev_mem [DEPTH];
  logic [AW-1:0]   free_mem [DEPTH];
  logic [AW-1:0]   ring_mem [DEPTH];

  // latched input
  logic                cmd_q;
  logic [ID_WIDTH-1:0] id_q;
  logic [LEN_W-1:0]    len_q;
  logic                ce_q;

  // list state
  logic [AW-1:0]    head_q, tail_q, ring_start_q;
  logic [CNT_W-1:0] count_q, ce_cnt_q, free_top_q, fresh_q;
  logic [BL_W-1:0]  backlog_q;

  // read data
  logic [PL_W-1:0] pl_rd_q;
  logic [AW-1:0]   next_rd_q, prev_rd_q, free_rd_q, ring_rd_q;

  // released packet and slot reuse after eviction
  logic [ID_WIDTH-1:0] rel_id_q;
  logic [LEN_W-1:0]    rel_len_q;
  logic                rel_ce_q;
  logic                reuse_q;
  logic [AW-1:0]       reuse_slot_q;

  logic [ID_WIDTH-1:0] rd_id;
  logic [LEN_W-1:0]    rd_len;
  logic                rd_ce;
  logic [AW-1:0]       slot_addr, free_addr, alloc_slot, ring_wr_addr, ring_newest;
  logic                v_first, v_last, v_middle;
  logic                next_we, prev_we;
  logic [AW-1:0]       next_wa, next_wd, prev_wa, prev_wd;
  logic [LW-1:0]       lim_ext, dep_ext, eff_limit;
  logic                arrive_ce;

  function automatic logic [AW-1:0] ring_wrap(input logic [AW:0] s);
    logic [AW:0] r;
    r = s;
    if (r >= (AW+1)'(DEPTH)) r = r - (AW+1)'(DEPTH);
    return r[AW-1:0];
  endfunction

  assign {rd_id, rd_len, rd_ce} = pl_rd_q;
  assign arrive_ce = is_ip_i && ((ecn_bits_i & ECN_FIELD_MASK) == ECN_CE_CODE);

  // effective limit, clipped to capacity
  assign lim_ext   = LW'(queue_limit_i);
  assign dep_ext   = LW'(DEPTH);
  assign eff_limit = (lim_ext > dep_ext) ? dep_ext : lim_ext;

  assign flags_o.is_dequeue  = (cmd_q == CMD_DEQUEUE);
  assign flags_o.is_empty    = (count_q == '0);
  assign flags_o.limit_zero  = (queue_limit_i == '0);
  assign flags_o.below_limit = (LW'(count_q) < eff_limit);
  assign flags_o.arrive_ce   = ce_q;
  assign flags_o.ce_held     = (ce_cnt_q != '0);

  // addresses
  assign slot_addr    = cmd_i.rd_victim ? ring_rd_q : head_q;
  assign free_addr    = (free_top_q == '0) ? '0 : AW'(free_top_q - CNT_W'(1));
  assign ring_wr_addr = ring_wrap((AW+1)'(ring_start_q) + (AW+1)'(ce_cnt_q));
  assign ring_newest  = ring_wrap((AW+1)'(ring_start_q) + (AW+1)'(ce_cnt_q) - (AW+1)'(1));
  assign alloc_slot   = reuse_q ? reuse_slot_q
                      : ((free_top_q != '0) ? free_rd_q : fresh_q[AW-1:0]);

  // victim position in the list
  assign v_first  = (ring_rd_q == head_q);
  assign v_last   = (ring_rd_q == tail_q);
  assign v_middle = !v_first && !v_last;

  // link write port selection
  always_comb begin
    next_we = 1'b0;
    next_wa = prev_rd_q;
    next_wd = next_rd_q;
    prev_we = 1'b0;
    prev_wa = next_rd_q;
    prev_wd = prev_rd_q;
    if (cmd_i.evict_commit && v_middle) begin
      next_we = 1'b1;
      prev_we = 1'b1;
    end else if (cmd_i.alloc_commit && (count_q != '0)) begin
      next_we = 1'b1;
      next_wa = tail_q;
      next_wd = alloc_slot;
      prev_we = 1'b1;
      prev_wa = alloc_slot;
      prev_wd = tail_q;
    end
  end

  // slot memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_head || cmd_i.rd_victim) begin
      pl_rd_q   <= pl_mem[slot_addr];
      next_rd_q <= next_mem[slot_addr];
      prev_rd_q <= prev_mem[slot_addr];
    end
    if (cmd_i.alloc_commit) pl_mem[alloc_slot] <= {id_q, len_q, ce_q};
    if (next_we) next_mem[next_wa] <= next_wd;
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
  end

  // free stack memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_free) free_rd_q <= free_mem[free_addr];
    if (cmd_i.deq_commit) free_mem[free_top_q[AW-1:0]] <= head_q;
  end

  // ce order ring memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_ring) ring_rd_q <= ring_mem[ring_newest];
    if (cmd_i.alloc_commit && ce_q) ring_mem[ring_wr_addr] <= alloc_slot;
  end

  // input latch, released packet and result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      cmd_q     <= command_i;
      id_q      <= packet_id_i;
      len_q     <= packet_length_i;
      ce_q      <= arrive_ce;
      rel_id_q  <= '0;
      rel_len_q <= '0;
      rel_ce_q  <= 1'b0;
    end else if (cmd_i.deq_commit) begin
      rel_id_q  <= rd_id;
      rel_len_q <= rd_len;
      rel_ce_q  <= rd_ce;
    end else if (cmd_i.evict_commit) begin
      rel_id_q     <= rd_id;
      rel_len_q    <= rd_len;
      rel_ce_q     <= 1'b1;
      reuse_slot_q <= ring_rd_q;
    end
    if (cmd_i.res_load) begin
      status_o          <= cmd_i.status;
      released_id_o     <= rel_id_q;
      released_length_o <= rel_len_q;
      released_ce_o     <= rel_ce_q;
      queue_count_o     <= CNT_OUT_W'(count_q);
      ce_count_o        <= CNT_OUT_W'(ce_cnt_q);
      backlog_bytes_o   <= backlog_q;
    end
  end

  // list pointers and totals
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q       <= '0;
      tail_q       <= '0;
      ring_start_q <= '0;
      count_q      <= '0;
      ce_cnt_q     <= '0;
      free_top_q   <= '0;
      fresh_q      <= '0;
      backlog_q    <= '0;
      reuse_q      <= 1'b0;
    end else begin
      if (cmd_i.latch_in) reuse_q <= 1'b0;
      if (cmd_i.deq_commit) begin
        head_q     <= next_rd_q;
        count_q    <= count_q - CNT_W'(1);
        backlog_q  <= backlog_q - BL_W'(rd_len);
        free_top_q <= free_top_q + CNT_W'(1);
        if (rd_ce && (ce_cnt_q != '0)) begin
          ring_start_q <= ring_wrap((AW+1)'(ring_start_q) + (AW+1)'(1));
          ce_cnt_q     <= ce_cnt_q - CNT_W'(1);
        end
      end
      if (cmd_i.evict_commit) begin
        if (v_first && !v_last) head_q <= next_rd_q;
        if (v_last && !v_first) tail_q <= prev_rd_q;
        count_q   <= count_q - CNT_W'(1);
        ce_cnt_q  <= ce_cnt_q - CNT_W'(1);
        backlog_q <= backlog_q - BL_W'(rd_len);
        reuse_q   <= 1'b1;
      end
      if (cmd_i.alloc_commit) begin
        if (count_q == '0) head_q <= alloc_slot;
        tail_q    <= alloc_slot;
        count_q   <= count_q + CNT_W'(1);
        backlog_q <= backlog_q + BL_W'(len_q);
        if (ce_q) ce_cnt_q <= ce_cnt_q + CNT_W'(1);
        if (!reuse_q) begin
          if (free_top_q != '0) free_top_q <= free_top_q - CNT_W'(1);
          else                  fresh_q    <= fresh_q + CNT_W'(1);
        end
      end
    end
  end

endmodule

@@ dv/tb_top.sv @@
// tb_top: self-checking bench for the ce push-out packet queue core
// depends on cepq_pkg, cepq_if and ce_pushout_packet_queue_core
`timescale 1ns / 1ps

module tb_top;
  import cepq_pkg::*;

  localparam int QD = DEPTH_DEF;
  localparam int LIMIT_CYCLES = 600000;

  typedef struct packed {
    logic        command;
    logic [15:0] packet_id;
    logic [15:0] packet_length;
    logic        is_ip;
    logic [1:0]  ecn_bits;
  } pkt_cmd_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] released_id;
    logic [15:0] released_length;
    logic        released_ce;
    logic [10:0] queue_count;
    logic [10:0] ce_count;
    logic [25:0] backlog_bytes;
  } pkt_res_t;

  // directed row: command plus optional typed-in status
  typedef struct packed {
    pkt_cmd_t cmd;
    logic     fixed;
    status_e  status;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  cepq_in_if  in_ch ();
  cepq_out_if out_ch ();

  ce_pushout_packet_queue_core DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch.sink), .out_o(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predictor state: held queue as ordered list of descriptors
  typedef struct packed {
    logic [15:0] id;
    logic [15:0] len;
    logic        ce;
  } held_pkt_t;

  held_pkt_t  held_q[$];
  logic [10:0] lim_reg = LIMIT_RESET;
  logic [25:0] backlog_acc = '0;
  int          ce_held = 0;
  pkt_res_t    expected_q[$];
  logic        fixed_q[$];
  int          errors = 0;
  int          cycles = 0;
  bit          quiet = 1'b0;

  function automatic pkt_res_t predict_step(pkt_cmd_t c);
    pkt_res_t r;
    int lim;
    int vi;
    logic ce;
    r = '0;
    if (c.command == CMD_DEQUEUE) begin
      if (held_q.size() == 0) r.status = ST_EMPTY;
      else begin
        r.status = ST_DEQUEUED;
        r.released_id = held_q[0].id;
        r.released_length = held_q[0].len;
        r.released_ce = held_q[0].ce;
        if (held_q[0].ce) ce_held--;
        backlog_acc = backlog_acc - 26'(held_q[0].len);
        held_q.pop_front();
      end
    end else begin
      ce = c.is_ip && ((c.ecn_bits & ECN_FIELD_MASK) == ECN_CE_CODE);
      lim = (lim_reg > QD) ? QD : lim_reg;
      if (lim == 0) r.status = ST_DROP_ZERO;
      else if (held_q.size() < lim) r.status = ST_ENQUEUED;
      else if (ce) r.status = ST_DROP_CE;
      else if (ce_held > 0) begin
        // newest ce packet is the last ce entry in queue order
        vi = held_q.size() - 1;
        while (!held_q[vi].ce) vi--;
        r.status = ST_EVICTED;
        r.released_id = held_q[vi].id;
        r.released_length = held_q[vi].len;
        r.released_ce = 1'b1;
        backlog_acc = backlog_acc - 26'(held_q[vi].len);
        held_q.delete(vi);
        ce_held--;
      end else r.status = ST_DROP_FULL;
      if (r.status inside {ST_ENQUEUED, ST_EVICTED}) begin
        held_q.push_back('{c.packet_id, c.packet_length, ce});
        backlog_acc = backlog_acc + 26'(c.packet_length);
        if (ce) ce_held++;
      end
    end
    r.queue_count = 11'(held_q.size());
    r.ce_count = 11'(ce_held);
    r.backlog_bytes = backlog_acc;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint exp);
    $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, exp, cycles);
    errors++;
  endtask

  // input side driver
  logic     in_valid = 1'b0;
  pkt_cmd_t in_data = '0;
  assign in_ch.valid = in_valid;
  assign in_ch.command = in_data.command;
  assign in_ch.packet_id = in_data.packet_id;
  assign in_ch.packet_length = in_data.packet_length;
  assign in_ch.is_ip = in_data.is_ip;
  assign in_ch.ecn_bits = in_data.ecn_bits;

  // receiver with random stall bursts
  logic out_ready = 1'b0;
  int   stall_left = 0;
  assign out_ch.ready = out_ready;

  always @(negedge clk_i) begin
    if (!quiet && stall_left == 0 && $urandom_range(0, 7) == 0)
      stall_left = $urandom_range(1, 13);
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else out_ready <= 1'b1;
  end

  // result check at rising edge
  always @(posedge clk_i) begin
    pkt_res_t e;
    logic fx;
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("ce_pushout_packet_queue_core test failed");
      $finish;
    end
    if (rst_ni && out_ch.valid && out_ready) begin
      if (expected_q.size() == 0) report_mismatch("unexpected result", out_ch.status, 0);
      else begin
        e = expected_q.pop_front();
        fx = fixed_q.pop_front();
        if (out_ch.status != e.status) report_mismatch("status", out_ch.status, e.status);
        if (!fx) begin
          if (out_ch.released_id != e.released_id)
            report_mismatch("released_id", out_ch.released_id, e.released_id);
          if (out_ch.released_length != e.released_length)
            report_mismatch("released_length", out_ch.released_length, e.released_length);
          if (out_ch.released_ce != e.released_ce)
            report_mismatch("released_ce", out_ch.released_ce, e.released_ce);
          if (out_ch.queue_count != e.queue_count)
            report_mismatch("queue_count", out_ch.queue_count, e.queue_count);
          if (out_ch.ce_count != e.ce_count)
            report_mismatch("ce_count", out_ch.ce_count, e.ce_count);
          if (out_ch.backlog_bytes != e.backlog_bytes)
            report_mismatch("backlog_bytes", out_ch.backlog_bytes, e.backlog_bytes);
        end
      end
    end
  end

  // one transfer in, with optional sender gap first; valid stays up until the next call
  task automatic send_cmd(pkt_cmd_t c, logic fx, status_e fst);
    pkt_res_t r;
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= c;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    r = predict_step(c);
    if (fx && r.status != fst) report_mismatch("directed table status", r.status, fst);
    expected_q.push_back(r);
    fixed_q.push_back(1'b0);
    @(negedge clk_i);
  endtask

  task automatic drain_wait();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (12) @(negedge clk_i);
  endtask

  task automatic write_limit(logic [10:0] v);
    drain_wait();
    psel <= 1'b1; pwrite <= 1'b1; paddr <= REG_QUEUE_LIMIT; pwdata <= 32'(v);
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    lim_reg = v;
  endtask

  function automatic pkt_cmd_t mk(logic cm, logic [15:0] id, logic [15:0] ln,
                                  logic ip, logic [1:0] ecn);
    pkt_cmd_t c;
    c.command = cm; c.packet_id = id; c.packet_length = ln; c.is_ip = ip; c.ecn_bits = ecn;
    return c;
  endfunction

  function automatic pkt_cmd_t rand_cmd(int deq_pct, int ce_pct);
    pkt_cmd_t c;
    c.packet_id = 16'($urandom);
    c.packet_length = 16'($urandom);
    c.command = ($urandom_range(0, 99) < deq_pct) ? CMD_DEQUEUE : CMD_ENQUEUE;
    if ($urandom_range(0, 99) < ce_pct) begin
      c.is_ip = 1'b1; c.ecn_bits = ECN_CE_CODE;
    end else begin
      c.is_ip = 1'($urandom); c.ecn_bits = 2'($urandom);
    end
    return c;
  endfunction

  dir_row_t dir_tab[$];

  initial begin
    int n;
    pkt_cmd_t c;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed rows, status typed in where obvious
    dir_tab.push_back('{mk(CMD_DEQUEUE, 16'h1234, 16'hffff, 1'b1, 2'd3), 1'b1, ST_EMPTY});
    dir_tab.push_back('{mk(CMD_ENQUEUE, 16'hffff, 16'hffff, 1'b1, 2'd3), 1'b1, ST_ENQUEUED});
    dir_tab.push_back('{mk(CMD_ENQUEUE, 16'h0000, 16'h0000, 1'b0, 2'd3), 1'b1, ST_ENQUEUED});
    dir_tab.push_back('{mk(CMD_ENQUEUE, 16'haaaa, 16'h5555, 1'b1, 2'd2), 1'b1, ST_ENQUEUED});
    dir_tab.push_back('{mk(CMD_DEQUEUE, 16'h0, 16'h0, 1'b0, 2'd0), 1'b1, ST_DEQUEUED});
    dir_tab.push_back('{mk(CMD_DEQUEUE, 16'h0, 16'h0, 1'b0, 2'd0), 1'b1, ST_DEQUEUED});
    dir_tab.push_back('{mk(CMD_DEQUEUE, 16'h0, 16'h0, 1'b0, 2'd0), 1'b1, ST_DEQUEUED});
    dir_tab.push_back('{mk(CMD_DEQUEUE, 16'h0, 16'h0, 1'b0, 2'd0), 1'b1, ST_EMPTY});
    foreach (dir_tab[i]) send_cmd(dir_tab[i].cmd, dir_tab[i].fixed, dir_tab[i].status);

    // zero limit drops everything
    write_limit(11'd0);
    send_cmd(mk(CMD_ENQUEUE, 16'h1, 16'h10, 1'b0, 2'd0), 1'b1, ST_DROP_ZERO);
    send_cmd(mk(CMD_ENQUEUE, 16'h2, 16'h10, 1'b1, 2'd3), 1'b1, ST_DROP_ZERO);

    // small limit: fill with mixed, then ce drop, evict from middle, no-victim drop
    write_limit(11'd3);
    send_cmd(mk(CMD_ENQUEUE, 16'h11, 16'd100, 1'b0, 2'd1), 1'b0, ST_ENQUEUED);
    send_cmd(mk(CMD_ENQUEUE, 16'h12, 16'd200, 1'b1, 2'd3), 1'b0, ST_ENQUEUED);
    send_cmd(mk(CMD_ENQUEUE, 16'h13, 16'd300, 1'b0, 2'd2), 1'b0, ST_ENQUEUED);
    send_cmd(mk(CMD_ENQUEUE, 16'h14, 16'd400, 1'b1, 2'd3), 1'b1, ST_DROP_CE);
    send_cmd(mk(CMD_ENQUEUE, 16'h15, 16'd500, 1'b1, 2'd1), 1'b1, ST_EVICTED);
    send_cmd(mk(CMD_ENQUEUE, 16'h16, 16'd600, 1'b0, 2'd0), 1'b1, ST_DROP_FULL);
    // lowering the limit below the count
    write_limit(11'd1);
    send_cmd(mk(CMD_ENQUEUE, 16'h17, 16'd7, 1'b0, 2'd0), 1'b1, ST_DROP_FULL);
    repeat (3) send_cmd(mk(CMD_DEQUEUE, 16'hffff, 16'hffff, 1'b1, 2'd3), 1'b0, ST_DEQUEUED);

    // random phases over several limits, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_limit(11'd2);
        1: write_limit(11'd5);
        2: write_limit(11'd2047);
        3: write_limit(11'd1024);
        4: write_limit(11'd8);
        default: write_limit(11'd1000);
      endcase
      if (ph == 5) quiet = 1'b1;
      n = 0;
      while (n < 105) begin
        // mostly fill until more than 12 are held, then churn with more dequeues
        c = rand_cmd((held_q.size() > 12) ? 55 : 30, 40);
        send_cmd(c, 1'b0, ST_ENQUEUED);
        n++;
      end
    end

    drain_wait();
    if (errors == 0) $display("ce_pushout_packet_queue_core test passed");
    else $display("ce_pushout_packet_queue_core test failed");
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/cepq_pkg.sv
hdl/cepq_if.sv
hdl/cepq_ctrl.sv
hdl/cepq_dp.sv
hdl/ce_pushout_packet_queue_core.sv
dv/tb_top.sv
